### src/mode_s_frame_classifier_macros.svh
// Assertion macros used by the Mode S frame classifier top level.
`ifndef MODE_S_FRAME_CLASSIFIER_MACROS_SVH
`define MODE_S_FRAME_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk edge outside reset.
`define MFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a consequence in the next cycle.
`define MFC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define MFC_ASSERT(label, prop, msg)
`define MFC_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

### src/mfc_pkg.sv
// Shared types and constants of the Mode S frame classifier.
package mfc_pkg;

    // Frame geometry in symbols
    localparam int unsigned SHORT_SYMBOLS     = 56;
    localparam int unsigned LONG_SYMBOLS      = 112;
    localparam int unsigned FIRST_TAIL_SYMBOL = 65;
    localparam int unsigned TAIL_SYMBOLS      = 5;

    // Reference level taps, in chips from the frame start
    localparam int unsigned REF_TAPS = 4;
    localparam int unsigned REF_CHIP_OFS [REF_TAPS] = '{0, 2, 7, 9};

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_FRUIT = 2'd2
    } frame_kind_t;

    // Preamble flags seen at the edges of the lookahead windows
    typedef struct packed {
        logic head;       // flag leaving both windows (frame start)
        logic short_edge; // flag entering the short window
        logic tail;       // flag entering the long window
    } window_flags_t;

endpackage

### src/mfc_cell.sv
// One delay cell of the sample line: a sample and its preamble flag.
module mfc_cell
    import mfc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  logic [SAMPLE_BITS-1:0] next_sample,
    input  logic                   next_flag,
    output logic [SAMPLE_BITS-1:0] sample,
    output logic                   flag
);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;
    logic                   flag_reg;
    logic                   flag_next;

    // Take the neighbor's content on each accepted request
    always_comb
    begin
        sample_next = sample_reg;
        flag_next   = flag_reg;
        if (shift)
        begin
            sample_next = next_sample;
            flag_next   = next_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            sample_reg <= sample_next;
            flag_reg   <= flag_next;
        end
    end

    assign sample = sample_reg;
    assign flag   = flag_reg;

endmodule

### src/mfc_classifier.sv
// Frame classification, window counters and output register.
module mfc_classifier
    import mfc_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_CHIP = 2,
    parameter int unsigned SAMPLE_BITS      = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   shift,
    input  logic [SAMPLE_BITS-1:0] head_sample,
    input  window_flags_t          flags,
    input  logic [SAMPLE_BITS-1:0] ref_tap   [REF_TAPS],
    input  logic [SAMPLE_BITS-1:0] chip0_tap [TAIL_SYMBOLS],
    input  logic [SAMPLE_BITS-1:0] chip1_tap [TAIL_SYMBOLS],
    output logic [SAMPLE_BITS-1:0] sample_out,
    output logic                   frame_mark,
    output logic [1:0]             frame_kind
);

    localparam int unsigned LINE_DEPTH = LONG_SYMBOLS * 2 * SAMPLES_PER_CHIP;
    localparam int unsigned COUNT_BITS = $clog2(LINE_DEPTH);
    localparam int unsigned SUM_BITS   = SAMPLE_BITS + 2;
    localparam int unsigned CMP_BITS   = SAMPLE_BITS + 3;

    logic                   accept;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] sample_out_reg;
    logic                   mark_reg;
    frame_kind_t            kind_reg;
    frame_kind_t            kind_next;
    logic [COUNT_BITS-1:0]  short_count_reg;
    logic [COUNT_BITS-1:0]  short_count_next;
    logic [COUNT_BITS-1:0]  long_count_reg;
    logic [COUNT_BITS-1:0]  long_count_next;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SAMPLE_BITS-1:0] max_reg  [TAIL_SYMBOLS];
    logic [SAMPLE_BITS-1:0] max_next [TAIL_SYMBOLS];
    logic                   any_empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign shift    = accept;

    // Prepare the reference sum and chip maxima for the next frame start
    always_comb
    begin
        sum_next = '0;
        for (int r = 0; r < REF_TAPS; r++)
        begin
            sum_next = sum_next + SUM_BITS'(ref_tap[r]);
        end
        for (int k = 0; k < TAIL_SYMBOLS; k++)
        begin
            max_next[k] = (chip0_tap[k] > chip1_tap[k]) ? chip0_tap[k] : chip1_tap[k];
        end
    end

    // Test each tail symbol: empty when 8 * max < reference sum
    always_comb
    begin
        any_empty = 1'b0;
        for (int k = 0; k < TAIL_SYMBOLS; k++)
        begin
            if ({max_reg[k], 3'b000} < CMP_BITS'(sum_reg))
            begin
                any_empty = 1'b1;
            end
        end
    end

    // Advance the window counters as flags enter and leave
    always_comb
    begin
        long_count_next  = long_count_reg + COUNT_BITS'(flags.tail)
                           - COUNT_BITS'(flags.head);
        short_count_next = short_count_reg + COUNT_BITS'(flags.short_edge)
                           - COUNT_BITS'(flags.head);
    end

    // Pick the frame kind from the tail test and the matching window
    always_comb
    begin
        kind_next = KIND_SHORT;
        if (flags.head)
        begin
            if (any_empty)
            begin
                kind_next = (short_count_next != '0) ? KIND_FRUIT : KIND_SHORT;
            end
            else
            begin
                kind_next = (long_count_next != '0) ? KIND_FRUIT : KIND_LONG;
            end
        end
    end

    // Hold a result until taken, refill on each accepted request
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            short_count_reg <= '0;
            long_count_reg  <= '0;
            sum_reg         <= '0;
            for (int k = 0; k < TAIL_SYMBOLS; k++)
            begin
                max_reg[k] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                short_count_reg <= short_count_next;
                long_count_reg  <= long_count_next;
                sum_reg         <= sum_next;
                for (int k = 0; k < TAIL_SYMBOLS; k++)
                begin
                    max_reg[k] <= max_next[k];
                end
            end
        end
    end

    // Payload of the output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_out_reg <= head_sample;
            mark_reg       <= flags.head;
            kind_reg       <= kind_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign frame_mark = mark_reg;
    assign frame_kind = kind_reg;

endmodule

### src/mode_s_frame_classifier.sv
// Mode S frame classifier top level. Samples with a preamble flag enter a
// chain of LINE_DEPTH = 224 * SAMPLES_PER_CHIP delay cells (448 at the default),
// and each accepted request returns the sample that entered LINE_DEPTH - 1
// requests earlier, together with a frame mark and a short, long or fruited
// classification of the frame starting there. One request is taken every
// cycle unless a waiting result is not taken; the result sits in the output
// register from the cycle after acceptance, and a new request is accepted
// while that result waits if it is taken in the same cycle. The chain shifts
// only on accepted requests, so throughput is one sample per clock while
// out_ready stays high, and latency through the line is counted in samples.
// After reset the first LINE_DEPTH - 1 results are zero samples with no mark.
`include "mode_s_frame_classifier_macros.svh"

module mode_s_frame_classifier
    import mfc_pkg::*;
#(
    parameter int unsigned SAMPLES_PER_CHIP = 2,
    parameter int unsigned SAMPLE_BITS      = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic                   preamble_flag,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] sample_out,
    output logic                   frame_mark,
    output logic [1:0]             frame_kind
);

    localparam int unsigned SYMBOL_SAMPLES = 2 * SAMPLES_PER_CHIP;
    localparam int unsigned SHORT_LOOK     = SHORT_SYMBOLS * SYMBOL_SAMPLES;
    localparam int unsigned LINE_DEPTH     = LONG_SYMBOLS * SYMBOL_SAMPLES;

    logic                   shift;
    logic [SAMPLE_BITS-1:0] line_sample [LINE_DEPTH];
    logic [LINE_DEPTH-1:0]  line_flag;
    window_flags_t          flags;
    logic [SAMPLE_BITS-1:0] ref_tap   [REF_TAPS];
    logic [SAMPLE_BITS-1:0] chip0_tap [TAIL_SYMBOLS];
    logic [SAMPLE_BITS-1:0] chip1_tap [TAIL_SYMBOLS];

    // Build the delay line: cell 0 holds the oldest sample
    for (genvar i = 0; i < LINE_DEPTH; i++)
    begin : g_cell
        if (i == LINE_DEPTH - 1)
        begin : g_tail
            mfc_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (shift),
                .next_sample (sample_in),
                .next_flag   (preamble_flag),
                .sample      (line_sample[i]),
                .flag        (line_flag[i])
            );
        end
        else
        begin : g_body
            mfc_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift       (shift),
                .next_sample (line_sample[i+1]),
                .next_flag   (line_flag[i+1]),
                .sample      (line_sample[i]),
                .flag        (line_flag[i])
            );
        end
    end

    // Tap the line two cells ahead so the classifier sees the next frame start
    for (genvar r = 0; r < REF_TAPS; r++)
    begin : g_ref_tap
        assign ref_tap[r] = line_sample[REF_CHIP_OFS[r] * SAMPLES_PER_CHIP + 2];
    end

    for (genvar k = 0; k < TAIL_SYMBOLS; k++)
    begin : g_tail_tap
        assign chip0_tap[k] = line_sample[(FIRST_TAIL_SYMBOL + k) * SYMBOL_SAMPLES + 2];
        assign chip1_tap[k] =
            line_sample[(FIRST_TAIL_SYMBOL + k) * SYMBOL_SAMPLES + SAMPLES_PER_CHIP + 2];
    end

    // Flags at the window edges after the coming shift
    assign flags.head       = line_flag[1];
    assign flags.short_edge = line_flag[SHORT_LOOK];
    assign flags.tail       = preamble_flag;

    mfc_classifier #(
        .SAMPLES_PER_CHIP (SAMPLES_PER_CHIP),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_classifier (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .shift       (shift),
        .head_sample (line_sample[1]),
        .flags       (flags),
        .ref_tap     (ref_tap),
        .chip0_tap   (chip0_tap),
        .chip1_tap   (chip1_tap),
        .sample_out  (sample_out),
        .frame_mark  (frame_mark),
        .frame_kind  (frame_kind)
    );

    // Checks on the line and the output register
    `MFC_ASSERT(a_no_kind_without_mark, (out_valid && !frame_mark) |-> (frame_kind == KIND_SHORT), "kind set on unmarked sample")
    `MFC_ASSERT_NEXT(a_accept_gives_result, (in_valid && in_ready), out_valid, "accepted request gave no result")
    `MFC_ASSERT(a_no_overwrite, (out_valid && !out_ready) |-> !in_ready, "result overwritten while stalled")
    `MFC_ASSERT_NEXT(a_head_flag_marks, (shift && line_flag[1]), frame_mark, "frame start lost its mark")

endmodule
